[rtl/sgpr_pkg.sv]
// Shared types, constants and helpers for the scaled glyph pixel renderer.
// No dependencies; used by sgpr_div_stage and the core top level.
package sgpr_pkg;

    localparam int FONT_BYTES    = 16384;
    localparam int FONT_AW       = $clog2(FONT_BYTES);
    localparam int MAX_GLYPH_DIM = 32;
    localparam int MAX_CELL_DIM  = 64;

    // dividend / quotient width of the scaling divider, and steps per stage
    localparam int DIV_W     = 12;
    localparam int DIV_STEPS = 4;

    localparam logic [9:0] SPACE_CODE = 10'h020;

    typedef enum logic [2:0] {
        CFG_GLYPH_WIDTH  = 3'd0,
        CFG_GLYPH_HEIGHT = 3'd1,
        CFG_GLYPH_COUNT  = 3'd2,
        CFG_DEST_WIDTH   = 3'd3,
        CFG_DEST_HEIGHT  = 3'd4,
        CFG_WINDOW_WIDTH = 3'd5,
        CFG_FORE_COLOR   = 3'd6,
        CFG_BACK_COLOR   = 3'd7
    } cfg_index_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_DRAW = 1'b1
    } item_kind_t;

    // restoring divider state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [5:0]       rem;
        logic [DIV_W-1:0] nq;
    } div_state_t;

    function automatic logic [5:0] clamp_glyph(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0) begin
            r = 6'd1;
        end else if (v > 6'(MAX_GLYPH_DIM)) begin
            r = 6'(MAX_GLYPH_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [6:0] clamp_cell(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > 7'(MAX_CELL_DIM)) begin
            r = 7'(MAX_CELL_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/sgpr_div_stage.sv]
// Four restoring-division steps of the nearest-neighbour scaling divider.
// Depends on sgpr_pkg (div_state_t, DIV_W, DIV_STEPS).
module sgpr_div_stage (
    input  sgpr_pkg::div_state_t st_i,
    input  logic [6:0]           divisor,
    output sgpr_pkg::div_state_t st_o
);

    always_comb begin
        sgpr_pkg::div_state_t s;
        logic [6:0] t;
        s = st_i;
        t = '0;
        for (int i = 0; i < sgpr_pkg::DIV_STEPS; i++) begin
            t = {s.rem, s.nq[sgpr_pkg::DIV_W-1]};
            if (t >= divisor) begin
                s.rem = 6'(t - divisor);
                s.nq  = {s.nq[sgpr_pkg::DIV_W-2:0], 1'b1};
            end else begin
                s.rem = t[5:0];
                s.nq  = {s.nq[sgpr_pkg::DIV_W-2:0], 1'b0};
            end
        end
        st_o = s;
    end

endmodule

[rtl/scaled_glyph_pixel_renderer_core.sv]
// Scaled glyph pixel renderer: font store plus pipelined pixel lookup.
// Depends on sgpr_pkg and sgpr_div_stage.
//
// Input words on s_* carry either a font byte load (s_tuser = 0) or a pixel
// draw (s_tuser = 1). Loads write the font store in pipeline order and give
// no result. Each draw gives one word on m_*: window byte address and color.
// The user must write registers on the cfg_* channel (always ready) only
// while idle; the block does not enforce it.
// Throughput: one word per cycle unless the output stalls. Stages: setup
// and multiplies, three stages of the scaling divider (four quotient bits
// each), font address and registered font read, color select into the
// output register. The whole pipeline advances together; when m_tvalid is
// high and m_tready low it freezes and s_tready drops, nothing lost or
// repeated. Reset (aresetn low, synchronous) empties the pipeline and
// restores register defaults; the font store has no reset and must be
// loaded before it is read.
module scaled_glyph_pixel_renderer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_index[13:0], load_byte[21:14], char_code[37:22], cell_col[43:38],
    // cell_row[49:44], origin_x[61:50], origin_y[73:62], zero [79:74]
    input  logic [79:0] s_tdata,
    // kind[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_address[27:0], pixel_color[59:28], zero [63:60]
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [5:0]  glyph_width_reg;
    logic [5:0]  glyph_height_reg;
    logic [9:0]  glyph_count_reg;
    logic [6:0]  dest_width_reg;
    logic [6:0]  dest_height_reg;
    logic [12:0] window_width_reg;
    logic [31:0] fore_color_reg;
    logic [31:0] back_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg  <= 6'd8;
            glyph_height_reg <= 6'd16;
            glyph_count_reg  <= 10'd256;
            dest_width_reg   <= 7'd8;
            dest_height_reg  <= 7'd16;
            window_width_reg <= 13'd640;
            fore_color_reg   <= 32'hFFFF_FFFF;
            back_color_reg   <= 32'h0;
        end else if (cfg_valid) begin
            unique case (sgpr_pkg::cfg_index_t'(cfg_index))
                sgpr_pkg::CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[5:0];
                sgpr_pkg::CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[5:0];
                sgpr_pkg::CFG_GLYPH_COUNT:  glyph_count_reg  <= cfg_data[9:0];
                sgpr_pkg::CFG_DEST_WIDTH:   dest_width_reg   <= cfg_data[6:0];
                sgpr_pkg::CFG_DEST_HEIGHT:  dest_height_reg  <= cfg_data[6:0];
                sgpr_pkg::CFG_WINDOW_WIDTH: window_width_reg <= cfg_data[12:0];
                sgpr_pkg::CFG_FORE_COLOR:   fore_color_reg   <= cfg_data;
                sgpr_pkg::CFG_BACK_COLOR:   back_color_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived sizes
    logic [5:0] gw_c, gh_c;
    logic [6:0] dw_c, dh_c;
    logic [2:0] row_bytes;
    logic [7:0] glyph_bytes;

    assign gw_c        = sgpr_pkg::clamp_glyph(glyph_width_reg);
    assign gh_c        = sgpr_pkg::clamp_glyph(glyph_height_reg);
    assign dw_c        = sgpr_pkg::clamp_cell(dest_width_reg);
    assign dh_c        = sgpr_pkg::clamp_cell(dest_height_reg);
    assign row_bytes   = 3'(({1'b0, gw_c} + 7'd7) >> 3);
    assign glyph_bytes = 8'(gh_c) * 8'(row_bytes);

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // input fields
    logic [13:0] in_load_index;
    logic [7:0]  in_load_byte;
    logic [15:0] in_code;
    logic [5:0]  in_col, in_row;
    logic [11:0] in_ox, in_oy;
    logic [9:0]  code_sel;

    assign in_load_index = s_tdata[13:0];
    assign in_load_byte  = s_tdata[21:14];
    assign in_code       = s_tdata[37:22];
    assign in_col        = s_tdata[43:38];
    assign in_row        = s_tdata[49:44];
    assign in_ox         = s_tdata[61:50];
    assign in_oy         = s_tdata[73:62];
    assign code_sel      = (in_code < {6'b0, glyph_count_reg}) ? in_code[9:0]
                                                               : sgpr_pkg::SPACE_CODE;

    // stage 1
    logic        v1_reg, draw1_reg;
    logic [13:0] li1_reg;
    logic [7:0]  lb1_reg;
    logic [9:0]  code1_reg;
    logic [7:0]  gb1_reg;
    logic [12:0] px1_reg, py1_reg;
    sgpr_pkg::div_state_t dx1_reg, dy1_reg;

    // stage 2
    logic        v2_reg, draw2_reg;
    logic [13:0] li2_reg, base2_reg;
    logic [7:0]  lb2_reg;
    logic [12:0] px2_reg;
    logic [25:0] prod2_reg;
    sgpr_pkg::div_state_t dx2_reg, dy2_reg, dx2_next, dy2_next;

    // stage 3
    logic        v3_reg, draw3_reg;
    logic [13:0] li3_reg, base3_reg;
    logic [7:0]  lb3_reg;
    logic [25:0] pix3_reg;
    sgpr_pkg::div_state_t dx3_reg, dy3_reg, dx3_next, dy3_next;

    // stage 4
    logic        v4_reg, draw4_reg;
    logic [13:0] li4_reg, base4_reg;
    logic [7:0]  lb4_reg;
    logic [25:0] pix4_reg;
    sgpr_pkg::div_state_t dx4_reg, dy4_reg, dx4_next, dy4_next;

    // stage 5
    logic        v5_reg, draw5_reg;
    logic [2:0]  bit5_reg;
    logic [25:0] pix5_reg;
    logic [7:0]  font_rd_reg;

    logic [17:0] base_full;
    logic [25:0] prod_full;
    logic [14:0] row_off;
    logic [13:0] font_addr;

    assign base_full = {8'b0, code1_reg} * {10'b0, gb1_reg};
    assign prod_full = {13'b0, py1_reg} * {13'b0, window_width_reg};
    assign row_off   = {3'b0, dy4_reg.nq} * {12'b0, row_bytes};
    assign font_addr = base4_reg + row_off[13:0] + {5'b0, dx4_reg.nq[11:3]};

    sgpr_div_stage u_divx_a (.st_i(dx1_reg), .divisor(dw_c), .st_o(dx2_next));
    sgpr_div_stage u_divy_a (.st_i(dy1_reg), .divisor(dh_c), .st_o(dy2_next));
    sgpr_div_stage u_divx_b (.st_i(dx2_reg), .divisor(dw_c), .st_o(dx3_next));
    sgpr_div_stage u_divy_b (.st_i(dy2_reg), .divisor(dh_c), .st_o(dy3_next));
    sgpr_div_stage u_divx_c (.st_i(dx3_reg), .divisor(dw_c), .st_o(dx4_next));
    sgpr_div_stage u_divy_c (.st_i(dy3_reg), .divisor(dh_c), .st_o(dy4_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            draw1_reg   <= (s_tuser[0] == sgpr_pkg::KIND_DRAW);
            li1_reg     <= in_load_index;
            lb1_reg     <= in_load_byte;
            code1_reg   <= code_sel;
            gb1_reg     <= glyph_bytes;
            px1_reg     <= {1'b0, in_ox} + {7'b0, in_col};
            py1_reg     <= {1'b0, in_oy} + {7'b0, in_row};
            dx1_reg.rem <= '0;
            dx1_reg.nq  <= 12'(in_col) * 12'(gw_c);
            dy1_reg.rem <= '0;
            dy1_reg.nq  <= 12'(in_row) * 12'(gh_c);

            draw2_reg <= draw1_reg;
            li2_reg   <= li1_reg;
            lb2_reg   <= lb1_reg;
            base2_reg <= base_full[13:0];
            prod2_reg <= prod_full;
            px2_reg   <= px1_reg;
            dx2_reg   <= dx2_next;
            dy2_reg   <= dy2_next;

            draw3_reg <= draw2_reg;
            li3_reg   <= li2_reg;
            lb3_reg   <= lb2_reg;
            base3_reg <= base2_reg;
            pix3_reg  <= prod2_reg + {13'b0, px2_reg};
            dx3_reg   <= dx3_next;
            dy3_reg   <= dy3_next;

            draw4_reg <= draw3_reg;
            li4_reg   <= li3_reg;
            lb4_reg   <= lb3_reg;
            base4_reg <= base3_reg;
            pix4_reg  <= pix3_reg;
            dx4_reg   <= dx4_next;
            dy4_reg   <= dy4_next;

            draw5_reg <= draw4_reg;
            bit5_reg  <= ~dx4_reg.nq[2:0];
            pix5_reg  <= pix4_reg;
        end
    end

    // font store: loads write and draws read at the same stage, in order
    logic [7:0] font_mem [sgpr_pkg::FONT_BYTES];

    always_ff @(posedge aclk) begin
        if (en && v4_reg) begin
            if (draw4_reg) begin
                font_rd_reg <= font_mem[font_addr];
            end else begin
                font_mem[li4_reg[sgpr_pkg::FONT_AW-1:0]] <= lb4_reg;
            end
        end
    end

    // output register
    logic [27:0] out_addr_reg;
    logic [31:0] out_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v5_reg && draw5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_addr_reg  <= {pix5_reg, 2'b00};
            out_color_reg <= font_rd_reg[bit5_reg] ? fore_color_reg : back_color_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_color_reg, out_addr_reg};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v5_reg && !draw5_reg) |=> !m_tvalid)
        else $error("load word produced a result");

    a_remx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> ({1'b0, dx4_reg.rem} < dw_c))
        else $error("x divider remainder out of range");

    a_remy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> ({1'b0, dy4_reg.rem} < dh_c))
        else $error("y divider remainder out of range");

endmodule

[test/tb_scaled_glyph_pixel_renderer_core.sv]
// Testbench for scaled_glyph_pixel_renderer_core: font loads and scaled pixel draws
// are checked against an in-bench pixel predictor under several register settings.
// Depends on sgpr_pkg and the core RTL; stands alone otherwise.
`timescale 1ns / 1ps

module tb_scaled_glyph_pixel_renderer_core;

    localparam int LAT_WAIT    = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 120;

    typedef struct {
        logic [27:0] addr;
        logic [31:0] color;
    } pixel_t;

    typedef struct {
        sgpr_pkg::item_kind_t kind;
        logic [13:0] lidx;
        logic [7:0]  lbyte;
        logic [15:0] code;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [11:0] ox;
        logic [11:0] oy;
        bit          typed;
        pixel_t      px;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [5:0]  gw_r, gh_r;
    logic [9:0]  gc_r;
    logic [6:0]  dw_r, dh_r;
    logic [12:0] ww_r;
    logic [31:0] fg_r, bg_r;

    logic [7:0]  font_mem [sgpr_pkg::FONT_BYTES];
    bit          font_written [sgpr_pkg::FONT_BYTES];
    pixel_t      pending_pixels [$];
    int          fail_count = 0;
    int          pixels_seen = 0;
    int          words_sent = 0;
    int          cfg_writes = 0;
    int          cycles = 0;
    int          stall_len = 0;

    scaled_glyph_pixel_renderer_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** scaled_glyph_pixel_renderer_core: FAILED **");
            $finish;
        end
    end

    function automatic int clamp_dim(input int v, input int hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic int glyph_byte_index(input logic [15:0] code_in,
                                            input logic [5:0] col, input logic [5:0] row);
        int gw, gh, dw, dh, rb, code, sx, sy;
        gw = clamp_dim(gw_r, sgpr_pkg::MAX_GLYPH_DIM);
        gh = clamp_dim(gh_r, sgpr_pkg::MAX_GLYPH_DIM);
        dw = clamp_dim(dw_r, sgpr_pkg::MAX_CELL_DIM);
        dh = clamp_dim(dh_r, sgpr_pkg::MAX_CELL_DIM);
        rb = (gw + 7) >> 3;
        code = (int'(code_in) >= int'(gc_r)) ? int'(sgpr_pkg::SPACE_CODE) : int'(code_in);
        sx = (int'(col) * gw) / dw;
        sy = (int'(row) * gh) / dh;
        return (code * gh * rb + sy * rb + (sx >> 3)) % sgpr_pkg::FONT_BYTES;
    endfunction

    function automatic pixel_t render_pixel(input logic [15:0] code, input logic [5:0] col,
                                            input logic [5:0] row, input logic [11:0] ox,
                                            input logic [11:0] oy);
        pixel_t p;
        int gw, dw, sx, fidx;
        longint pix;
        gw = clamp_dim(gw_r, sgpr_pkg::MAX_GLYPH_DIM);
        dw = clamp_dim(dw_r, sgpr_pkg::MAX_CELL_DIM);
        sx = (int'(col) * gw) / dw;
        fidx = glyph_byte_index(code, col, row);
        pix = longint'(ox) + longint'(col) + (longint'(oy) + longint'(row)) * longint'(ww_r);
        p.addr = 28'(pix * 4);
        p.color = font_mem[fidx][7 - (sx & 7)] ? fg_r : bg_r;
        return p;
    endfunction

    task automatic send_word(input sgpr_pkg::item_kind_t kind, input logic [13:0] lidx,
                             input logic [7:0] lbyte, input logic [15:0] code,
                             input logic [5:0] col, input logic [5:0] row,
                             input logic [11:0] ox, input logic [11:0] oy,
                             input bit typed, input pixel_t typed_px);
        int gap;
        bit rdy;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, oy, ox, row, col, code, lbyte, lidx};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        words_sent++;
        if (kind == sgpr_pkg::KIND_LOAD) begin
            font_mem[lidx] = lbyte;
            font_written[lidx] = 1'b1;
        end else begin
            pending_pixels.push_back(typed ? typed_px : render_pixel(code, col, row, ox, oy));
        end
    endtask

    task automatic send_load(input logic [13:0] lidx, input logic [7:0] lbyte);
        pixel_t none;
        none = '{default: '0};
        send_word(sgpr_pkg::KIND_LOAD, lidx, lbyte, '0, '0, '0, '0, '0, 1'b0, none);
    endtask

    // unwritten font bytes get loaded just ahead of the draw that reads them
    task automatic send_draw(input logic [15:0] code, input logic [5:0] col,
                             input logic [5:0] row, input logic [11:0] ox,
                             input logic [11:0] oy, input bit typed, input pixel_t px);
        int fidx;
        fidx = glyph_byte_index(code, col, row);
        if (!font_written[fidx]) send_load(14'(fidx), 8'($urandom));
        send_word(sgpr_pkg::KIND_DRAW, '0, '0, code, col, row, ox, oy, typed, px);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (LAT_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(input sgpr_pkg::cfg_index_t idx, input logic [31:0] val);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(negedge aclk);
            rdy = cfg_ready;
            @(posedge aclk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            sgpr_pkg::CFG_GLYPH_WIDTH:  gw_r = val[5:0];
            sgpr_pkg::CFG_GLYPH_HEIGHT: gh_r = val[5:0];
            sgpr_pkg::CFG_GLYPH_COUNT:  gc_r = val[9:0];
            sgpr_pkg::CFG_DEST_WIDTH:   dw_r = val[6:0];
            sgpr_pkg::CFG_DEST_HEIGHT:  dh_r = val[6:0];
            sgpr_pkg::CFG_WINDOW_WIDTH: ww_r = val[12:0];
            sgpr_pkg::CFG_FORE_COLOR:   fg_r = val;
            sgpr_pkg::CFG_BACK_COLOR:   bg_r = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [31:0] cfg_pick(input int phase, input int i);
        logic [31:0] lo [8];
        logic [31:0] hi [8];
        int sel;
        lo = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        hi = '{32'd63, 32'd63, 32'd1023, 32'd127, 32'd127, 32'd8191,
               32'hFFFF_FFFF, 32'hFFFF_FFFF};
        if (phase == 1) return lo[i];
        if (phase == 2) return hi[i];
        if (phase == 3) begin
            lo = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0};
            hi = '{32'd32, 32'd32, 32'd512, 32'd64, 32'd64, 32'd4096, 32'd0, 32'd0};
            return (i < 6) ? hi[i] : 32'($urandom);
        end
        sel = $urandom_range(0, 7);
        if (sel == 0) return lo[i];
        if (sel == 1) return hi[i];
        case (i)
            0, 1: return $urandom_range(1, 32);
            2: return $urandom_range(1, 512);
            3, 4: return $urandom_range(1, 64);
            5: return $urandom_range(1, 4096);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        dir_row_t tbl [$];
        pixel_t px;
        logic [15:0] code;
        logic [5:0] col, row;
        gw_r = 6'd8; gh_r = 6'd16; gc_r = 10'd256; dw_r = 7'd8; dh_r = 7'd16;
        ww_r = 13'd640; fg_r = 32'hFFFF_FFFF; bg_r = 32'd0;
        px = '{default: '0};
        tbl.push_back('{sgpr_pkg::KIND_LOAD, 14'd0, 8'h80, 0, 0, 0, 0, 0, 0, px});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd0, 6'd0, 6'd0, 12'd0, 12'd0, 1,
                        '{28'd0, 32'hFFFF_FFFF}});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd0, 6'd1, 6'd0, 12'd0, 12'd0, 1,
                        '{28'd4, 32'd0}});
        tbl.push_back('{sgpr_pkg::KIND_LOAD, 14'd512, 8'hFF, 0, 0, 0, 0, 0, 0, px});
        // out-of-range code falls back to the space glyph
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'hFFFF, 6'd0, 6'd0, 12'd4095,
                        12'd4095, 1, '{28'd10499580, 32'hFFFF_FFFF}});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd256, 6'd7, 6'd0, 12'd0, 12'd0, 1,
                        '{28'd28, 32'hFFFF_FFFF}});
        tbl.push_back('{sgpr_pkg::KIND_LOAD, 14'd16383, 8'h01, 0, 0, 0, 0, 0, 0, px});
        tbl.push_back('{sgpr_pkg::KIND_LOAD, 14'd4095, 8'h55, 0, 0, 0, 0, 0, 0, px});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd255, 6'd7, 6'd15, 12'd1, 12'd2,
                        0, px});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd255, 6'd6, 6'd15, 12'd0, 12'd0,
                        0, px});
        // outside the cell: read goes on with the scaled coordinate
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd65, 6'd63, 6'd63, 12'd4095, 12'd0,
                        0, px});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd255, 6'd63, 6'd63, 12'd2048,
                        12'd4095, 0, px});
        tbl.push_back('{sgpr_pkg::KIND_DRAW, 0, 0, 16'd32, 6'd42, 6'd21, 12'd2730,
                        12'd1365, 0, px});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (tbl[i]) begin
            if (tbl[i].kind == sgpr_pkg::KIND_LOAD) send_load(tbl[i].lidx, tbl[i].lbyte);
            else send_draw(tbl[i].code, tbl[i].col, tbl[i].row, tbl[i].ox, tbl[i].oy,
                           tbl[i].typed, tbl[i].px);
        end

        for (int ph = 1; ph <= PHASES; ph++) begin
            wait_idle();
            for (int r = 0; r < 8; r++) cfg_write(sgpr_pkg::cfg_index_t'(r), cfg_pick(ph, r));
            if (ph == 4) stall_len = 300;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_load(14'($urandom), 8'($urandom));
                end else begin
                    code = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                         : 16'($urandom_range(0, (gc_r == 0) ? 0 : gc_r - 1));
                    if ($urandom_range(0, 5) == 0) begin
                        col = 6'($urandom);
                        row = 6'($urandom);
                    end else begin
                        col = 6'($urandom_range(0,
                                  clamp_dim(dw_r, sgpr_pkg::MAX_CELL_DIM) - 1));
                        row = 6'($urandom_range(0,
                                  clamp_dim(dh_r, sgpr_pkg::MAX_CELL_DIM) - 1));
                    end
                    send_draw(code, col, row, 12'($urandom), 12'($urandom), 1'b0, px);
                end
            end
        end

        wait_idle();
        repeat (LAT_WAIT) @(posedge aclk);
        $display("sent %0d words, checked %0d pixels, %0d register writes over %0d settings",
                 words_sent, pixels_seen, cfg_writes, PHASES + 1);
        if (fail_count == 0 && pending_pixels.size() == 0) begin
            $display("** scaled_glyph_pixel_renderer_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d pixels missing", fail_count, pending_pixels.size());
            $display("** scaled_glyph_pixel_renderer_core: FAILED **");
        end
        $finish;
    end

    initial begin
        int gap;
        bit hit;
        logic [63:0] word;
        pixel_t exp_px;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (stall_len > 0) begin
                gap = stall_len;
                stall_len = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                hit = m_tvalid;
                word = m_tdata;
                @(posedge aclk);
            end while (!hit);
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $error("pixel word with nothing expected: %h", word);
                fail_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (word[27:0] !== exp_px.addr) begin
                    $error("pixel_address expected %h got %h", exp_px.addr, word[27:0]);
                    fail_count++;
                end
                if (word[59:28] !== exp_px.color) begin
                    $error("pixel_color expected %h got %h", exp_px.color, word[59:28]);
                    fail_count++;
                end
            end
        end
    end

endmodule
